// ===== design/rptg_pkg.sv =====
// ----------------------------------------------------------------------------
// rptg_pkg
// Shared types and constants for the resampling phase table generator.
// ----------------------------------------------------------------------------
package rptg_pkg;

    localparam int ACC_W   = 12;
    localparam int IDX_W   = 13;
    localparam int STEP_W  = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [ACC_W-1:0] PHASE_STEP  = 12'd256;
    localparam logic [IDX_W-1:0] WIDE_LENGTH = 13'd512;
    localparam logic [ACC_W-1:0] WIDTH_RESET = 12'd256;

    localparam logic [6:0] WEIGHT_FULL = 7'h40;
    localparam logic [5:0] WEIGHT_SAT  = 6'h3F;

    localparam logic [1:0] CARRY_MAIN   = 2'h3;
    localparam logic [1:0] CARRY_NOWRAP = 2'h1;
    localparam logic [1:0] CARRY_NONE   = 2'h0;

    // Divider step counts for each use of the shared unit
    localparam logic [STEP_W-1:0] STEPS_MOD    = 4'd12;
    localparam logic [STEP_W-1:0] STEPS_WEIGHT = 4'd6;
    localparam logic [STEP_W-1:0] STEPS_WRAP   = 4'd9;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MOD,
        ST_SEL,
        ST_WEIGHT,
        ST_WRAP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [ACC_W-1:0]  rem_init;
        logic [ACC_W-1:0]  dividend;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] quot;
        logic [ACC_W-1:0] rem;
    } div_rsp_t;

endpackage

// ===== design/rptg_div.sv =====
// ----------------------------------------------------------------------------
// rptg_div
// Restoring divider, one quotient bit per cycle. The partial remainder starts
// at rem_init (must be below the divisor) and dividend bits enter MSB first;
// after the given number of steps the low bits of quot hold the quotient.
// ----------------------------------------------------------------------------
module rptg_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [rptg_pkg::ACC_W-1:0] divisor,
    input  rptg_pkg::div_req_t        req,
    output rptg_pkg::div_rsp_t        rsp
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [rptg_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic [rptg_pkg::ACC_W-1:0]   rem_reg, rem_next;
    logic [rptg_pkg::ACC_W-1:0]   quo_reg, quo_next;

    logic [rptg_pkg::ACC_W:0]     trial;
    logic [rptg_pkg::ACC_W:0]     diff;
    logic                         fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[rptg_pkg::ACC_W-1]};
        diff  = trial - {1'b0, divisor};
        fits  = trial >= {1'b0, divisor};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = req.rem_init;
            quo_next  = req.dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[rptg_pkg::ACC_W-1:0] : trial[rptg_pkg::ACC_W-1:0];
            quo_next = {quo_reg[rptg_pkg::ACC_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == rptg_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== design/resample_phase_table_generator.sv =====
// ----------------------------------------------------------------------------
// resample_phase_table_generator
// At most one table entry per request, computed with a shared serial divider.
// ----------------------------------------------------------------------------
// Steps: a filler entry needs no division; a wide entry needs one (weight) and
// a narrow main entry two (weight, then wrap count); the phase accumulator is
// first reduced when it is not below the width, as after a width change.
// A request that comes after the table has ended gives no entry.
// One request at a time: the next is accepted once the result is loaded, which waits while the output is stalled.
// Reset: width 256, keep_full_scale 1, accumulator and counters cleared.
// ----------------------------------------------------------------------------
module resample_phase_table_generator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rptg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rptg_pkg::ACC_W-1:0]        cfg_data,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic                              restart,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [7:0]                        packed_byte,
    output logic [6:0]                        weight,
    output logic [1:0]                        carry,
    output logic [rptg_pkg::IDX_W-1:0]        entry_index,
    output logic                              table_last
);

    rptg_pkg::state_t state_reg, state_next;

    logic [rptg_pkg::ACC_W-1:0] width_reg;
    logic                       keep_reg;
    logic [rptg_pkg::ACC_W-1:0] w_eff;
    logic                       wide;

    logic [rptg_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [rptg_pkg::ACC_W-1:0] filler_reg, filler_next;
    logic [rptg_pkg::IDX_W-1:0] count_reg, count_next;
    logic                       fin_reg, fin_next;

    logic [6:0]                 pw_reg, pw_next;
    logic [1:0]                 pc_reg, pc_next;
    logic [rptg_pkg::IDX_W-1:0] pi_reg, pi_next;
    logic                       pl_reg, pl_next;

    logic                       res_valid_reg, res_valid_next;
    logic [7:0]                 ob_reg, ob_next;
    logic [6:0]                 ow_reg, ow_next;
    logic [1:0]                 oc_reg, oc_next;
    logic [rptg_pkg::IDX_W-1:0] oi_reg, oi_next;
    logic                       ol_reg, ol_next;

    rptg_pkg::div_req_t div_req;
    rptg_pkg::div_rsp_t div_rsp;

    logic                       accept;
    logic                       out_free;
    logic                       acc_big;
    logic [rptg_pkg::ACC_W:0]   acc_sum;
    logic [rptg_pkg::ACC_W:0]   acc_sub;
    logic [rptg_pkg::IDX_W-1:0] count_inc;
    logic [rptg_pkg::ACC_W-1:0] filler_dec;
    logic [rptg_pkg::ACC_W-1:0] wraps_less;
    logic [5:0]                 pack_w;

    rptg_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .divisor (w_eff),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= rptg_pkg::WIDTH_RESET;
            keep_reg  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rptg_pkg::REG_WIDTH: width_reg <= cfg_data;
                rptg_pkg::REG_KEEP:  keep_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        w_eff      = (width_reg == '0) ? rptg_pkg::ACC_W'(1) : width_reg;
        wide       = w_eff > rptg_pkg::PHASE_STEP;
        accept     = req_valid && req_ready;
        out_free   = !res_valid_reg || res_ready;
        acc_big    = acc_reg >= w_eff;
        acc_sum    = {1'b0, acc_reg} + {1'b0, rptg_pkg::PHASE_STEP};
        acc_sub    = acc_sum - {1'b0, w_eff};
        count_inc  = count_reg + 1'b1;
        filler_dec = filler_reg - 1'b1;
        wraps_less = (div_rsp.quot == '0) ? '0 : div_rsp.quot - 1'b1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rptg_pkg::ST_IDLE:
                if (accept)
                    state_next = rptg_pkg::ST_CHECK;
            rptg_pkg::ST_CHECK:
                if (fin_reg)
                    state_next = rptg_pkg::ST_IDLE;
                else if (acc_big)
                    state_next = rptg_pkg::ST_MOD;
                else
                    state_next = rptg_pkg::ST_SEL;
            rptg_pkg::ST_MOD:
                if (div_rsp.done)
                    state_next = rptg_pkg::ST_SEL;
            rptg_pkg::ST_SEL:
                if (wide)
                    state_next = (count_reg >= rptg_pkg::WIDE_LENGTH) ?
                                 rptg_pkg::ST_IDLE : rptg_pkg::ST_WEIGHT;
                else if (filler_reg != '0)
                    state_next = rptg_pkg::ST_EMIT;
                else
                    state_next = (count_reg >= rptg_pkg::IDX_W'(rptg_pkg::PHASE_STEP)) ?
                                 rptg_pkg::ST_IDLE : rptg_pkg::ST_WEIGHT;
            rptg_pkg::ST_WEIGHT:
                if (div_rsp.done)
                    state_next = wide ? rptg_pkg::ST_EMIT : rptg_pkg::ST_WRAP;
            rptg_pkg::ST_WRAP:
                if (div_rsp.done)
                    state_next = rptg_pkg::ST_EMIT;
            rptg_pkg::ST_EMIT:
                if (out_free)
                    state_next = rptg_pkg::ST_IDLE;
            default:
                state_next = rptg_pkg::ST_IDLE;
        endcase
    end

    // datapath and divider control
    always_comb
    begin
        acc_next       = acc_reg;
        filler_next    = filler_reg;
        count_next     = count_reg;
        fin_next       = fin_reg;
        pw_next        = pw_reg;
        pc_next        = pc_reg;
        pi_next        = pi_reg;
        pl_next        = pl_reg;
        res_valid_next = res_valid_reg && !res_ready;
        ob_next        = ob_reg;
        ow_next        = ow_reg;
        oc_next        = oc_reg;
        oi_next        = oi_reg;
        ol_next        = ol_reg;
        div_req        = '0;
        pack_w         = (!keep_reg || pw_reg == rptg_pkg::WEIGHT_FULL) ?
                         rptg_pkg::WEIGHT_SAT : pw_reg[5:0];

        unique case (state_reg)
            rptg_pkg::ST_IDLE:
                if (accept && restart)
                begin
                    acc_next    = '0;
                    filler_next = '0;
                    count_next  = '0;
                    fin_next    = 1'b0;
                end
            rptg_pkg::ST_CHECK:
                if (!fin_reg && acc_big)
                begin
                    div_req.start    = 1'b1;
                    div_req.steps    = rptg_pkg::STEPS_MOD;
                    div_req.rem_init = '0;
                    div_req.dividend = acc_reg;
                end
            rptg_pkg::ST_MOD:
                if (div_rsp.done)
                    acc_next = div_rsp.rem;
            rptg_pkg::ST_SEL:
            begin
                pi_next = count_reg;
                if (wide)
                    filler_next = '0;
                if (wide ? (count_reg >= rptg_pkg::WIDE_LENGTH) :
                    (filler_reg == '0 &&
                     count_reg >= rptg_pkg::IDX_W'(rptg_pkg::PHASE_STEP)))
                begin
                    fin_next = 1'b1;
                end
                else if (!wide && filler_reg != '0)
                begin
                    // filler entry: no arithmetic needed
                    pw_next     = '0;
                    pc_next     = rptg_pkg::CARRY_NONE;
                    filler_next = filler_dec;
                    count_next  = count_inc;
                    pl_next     = (filler_dec == '0) &&
                                  (count_inc >= rptg_pkg::IDX_W'(rptg_pkg::PHASE_STEP));
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.steps    = rptg_pkg::STEPS_WEIGHT;
                    div_req.rem_init = acc_reg;
                    div_req.dividend = '0;
                end
            end
            rptg_pkg::ST_WEIGHT:
                if (div_rsp.done)
                begin
                    pw_next = rptg_pkg::WEIGHT_FULL - {1'b0, div_rsp.quot[5:0]};
                    if (wide)
                    begin
                        if (acc_sum < {1'b0, w_eff})
                        begin
                            pc_next  = rptg_pkg::CARRY_NOWRAP;
                            acc_next = acc_sum[rptg_pkg::ACC_W-1:0];
                        end
                        else
                        begin
                            pc_next  = rptg_pkg::CARRY_NONE;
                            acc_next = acc_sub[rptg_pkg::ACC_W-1:0];
                        end
                        count_next = count_inc;
                        pl_next    = count_inc >= rptg_pkg::WIDE_LENGTH;
                    end
                    else
                    begin
                        // advanced phase stays below twice the phase step
                        pc_next          = rptg_pkg::CARRY_MAIN;
                        div_req.start    = 1'b1;
                        div_req.steps    = rptg_pkg::STEPS_WRAP;
                        div_req.rem_init = '0;
                        div_req.dividend = {acc_sum[8:0], 3'b000};
                    end
                end
            rptg_pkg::ST_WRAP:
                if (div_rsp.done)
                begin
                    acc_next    = div_rsp.rem;
                    filler_next = wraps_less;
                    count_next  = count_inc;
                    pl_next     = (wraps_less == '0) &&
                                  (count_inc >= rptg_pkg::IDX_W'(rptg_pkg::PHASE_STEP));
                end
            rptg_pkg::ST_EMIT:
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    ob_next        = {pc_reg, pack_w};
                    ow_next        = pw_reg;
                    oc_next        = pc_reg;
                    oi_next        = pi_reg;
                    ol_next        = pl_reg;
                    if (pl_reg)
                        fin_next = 1'b1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rptg_pkg::ST_IDLE;
            acc_reg       <= '0;
            filler_reg    <= '0;
            count_reg     <= '0;
            fin_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            filler_reg    <= filler_next;
            count_reg     <= count_next;
            fin_reg       <= fin_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pw_reg <= pw_next;
        pc_reg <= pc_next;
        pi_reg <= pi_next;
        pl_reg <= pl_next;
        ob_reg <= ob_next;
        ow_reg <= ow_next;
        oc_reg <= oc_next;
        oi_reg <= oi_next;
        ol_reg <= ol_next;
    end

    assign req_ready   = (state_reg == rptg_pkg::ST_IDLE);
    assign res_valid   = res_valid_reg;
    assign packed_byte = ob_reg;
    assign weight      = ow_reg;
    assign carry       = oc_reg;
    assign entry_index = oi_reg;
    assign table_last  = ol_reg;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the resampling phase table generator. A table of directed
// requests and register writes is walked first, then random request runs in
// narrow and wide mode. Every accepted request goes through a local
// phase-accumulator predictor. Every returned entry is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned MAX_REPORTS   = 30;

    typedef struct packed {
        logic [7:0]                 pb;
        logic [6:0]                 wt;
        logic [1:0]                 cy;
        logic [rptg_pkg::IDX_W-1:0] idx;
        logic                       last;
    } entry_t;

    typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                      kind;
        logic [rptg_pkg::CFG_IDX_W-1:0] sel;
        logic [rptg_pkg::ACC_W-1:0]     val;
        bit                             rs;
        bit                             typed;
        entry_t                         e;
    } step_row_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [rptg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rptg_pkg::ACC_W-1:0]     cfg_data  = '0;
    logic                           req_valid = 1'b0;
    logic                           req_ready;
    logic                           restart   = 1'b0;
    logic                           res_valid;
    logic                           res_ready = 1'b0;
    logic [7:0]                     packed_byte;
    logic [6:0]                     weight;
    logic [1:0]                     carry;
    logic [rptg_pkg::IDX_W-1:0]     entry_index;
    logic                           table_last;

    // typed expectation travels with the request it belongs to
    bit                             row_typed   = 1'b0;
    entry_t                         row_typed_e = '0;

    // predictor copy of registers and state
    logic [rptg_pkg::ACC_W-1:0]     cfg_width = rptg_pkg::WIDTH_RESET;
    bit                             cfg_keep  = 1'b1;
    logic [rptg_pkg::ACC_W-1:0]     acc_q     = '0;
    logic [rptg_pkg::ACC_W-1:0]     filler_q  = '0;
    logic [rptg_pkg::IDX_W-1:0]     entries_q = '0;
    bit                             done_q    = 1'b0;

    entry_t               entry_q[$];
    step_row_t            plan_q[$];

    int unsigned          errors       = 0;
    int unsigned          accepted     = 0;
    int unsigned          silent       = 0;
    int unsigned          checked      = 0;
    int unsigned          tables_done  = 0;
    int unsigned          rnd_items    = 0;
    int unsigned          tx_idle_pct  = 0;
    int unsigned          rx_idle_pct  = 0;
    int unsigned          hold_reqs    = 0;
    int unsigned          hold_seen    = 0;
    int unsigned          hold_left    = 0;

    entry_t               mon_e;
    entry_t               got_e;
    bit                   mon_has;

    resample_phase_table_generator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .restart     (restart),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .packed_byte (packed_byte),
        .weight      (weight),
        .carry       (carry),
        .entry_index (entry_index),
        .table_last  (table_last)
    );

    always #4 clk = ~clk;

    // Advance the table by one request; returns 0 when no entry comes out.
    function automatic bit next_entry(input bit rs, output entry_t e);
        int unsigned w;
        int unsigned a;
        int unsigned wraps;
        int unsigned wt;
        logic [1:0]  cy;
        bit          last;
        logic [5:0]  p;
        e = '0;
        w = (cfg_width == '0) ? 1 : cfg_width;
        if (rs)
        begin
            acc_q     = '0;
            filler_q  = '0;
            entries_q = '0;
            done_q    = 1'b0;
        end
        if (done_q)
            return 1'b0;
        a     = acc_q % w;
        acc_q = 12'(a);
        e.idx = entries_q;
        if (w > rptg_pkg::PHASE_STEP)
        begin
            filler_q = '0;
            if (entries_q >= rptg_pkg::WIDE_LENGTH)
            begin
                done_q = 1'b1;
                return 1'b0;
            end
            wt = 64 - (a * 64) / w;
            a  = a + rptg_pkg::PHASE_STEP;
            if (a < w)
                cy = rptg_pkg::CARRY_NOWRAP;
            else
            begin
                cy = rptg_pkg::CARRY_NONE;
                a  = a - w;
            end
            entries_q = entries_q + 1'b1;
            last      = (entries_q >= rptg_pkg::WIDE_LENGTH);
        end
        else if (filler_q != '0)
        begin
            wt        = 0;
            cy        = rptg_pkg::CARRY_NONE;
            filler_q  = filler_q - 1'b1;
            entries_q = entries_q + 1'b1;
            last      = (filler_q == '0) && (entries_q >= rptg_pkg::PHASE_STEP);
        end
        else
        begin
            if (entries_q >= rptg_pkg::PHASE_STEP)
            begin
                done_q = 1'b1;
                return 1'b0;
            end
            wt        = 64 - (a * 64) / w;
            cy        = rptg_pkg::CARRY_MAIN;
            a         = a + rptg_pkg::PHASE_STEP;
            wraps     = a / w;
            a         = a % w;
            // extra wraps become zero-weight fillers
            filler_q  = (wraps > 0) ? 12'(wraps - 1) : '0;
            entries_q = entries_q + 1'b1;
            last      = (filler_q == '0) && (entries_q >= rptg_pkg::PHASE_STEP);
        end
        acc_q = 12'(a);
        if (last)
            done_q = 1'b1;
        p      = (!cfg_keep || wt == rptg_pkg::WEIGHT_FULL) ? rptg_pkg::WEIGHT_SAT : 6'(wt);
        e.pb   = {cy, p};
        e.wt   = 7'(wt);
        e.cy   = cy;
        e.last = last;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h",
                     $time, what, got, want);
    endtask

    function automatic void plan_req(input bit rs);
        step_row_t r;
        r.kind  = ROW_REQ;
        r.sel   = rptg_pkg::REG_WIDTH;
        r.val   = '0;
        r.rs    = rs;
        r.typed = 1'b0;
        r.e     = '0;
        plan_q.insert(plan_q.size(), r);
    endfunction

    function automatic void plan_typed(input bit rs, input logic [7:0] pb,
                                       input logic [6:0] wt, input logic [1:0] cy,
                                       input logic [rptg_pkg::IDX_W-1:0] idx,
                                       input bit last);
        step_row_t r;
        r.kind  = ROW_REQ;
        r.sel   = rptg_pkg::REG_WIDTH;
        r.val   = '0;
        r.rs    = rs;
        r.typed = 1'b1;
        r.e     = '{pb: pb, wt: wt, cy: cy, idx: idx, last: last};
        plan_q.insert(plan_q.size(), r);
    endfunction

    function automatic void plan_cfg(input logic [rptg_pkg::CFG_IDX_W-1:0] sel,
                                     input logic [rptg_pkg::ACC_W-1:0] val);
        step_row_t r;
        r.kind  = ROW_CFG;
        r.sel   = sel;
        r.val   = val;
        r.rs    = 1'b0;
        r.typed = 1'b0;
        r.e     = '0;
        plan_q.insert(plan_q.size(), r);
    endfunction

    // Predict on every accepted request, check every accepted entry.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                got_e = '{pb: packed_byte, wt: weight, cy: carry,
                          idx: entry_index, last: table_last};
                if (entry_q.size() == 0)
                    flag_mismatch("entry with nothing pending", got_e.idx, 0);
                else
                begin
                    mon_e = entry_q.pop_front();
                    checked++;
                    if (got_e.last)
                        tables_done++;
                    if (got_e.pb != mon_e.pb)
                        flag_mismatch("packed_byte", got_e.pb, mon_e.pb);
                    if (got_e.wt != mon_e.wt)
                        flag_mismatch("weight", got_e.wt, mon_e.wt);
                    if (got_e.cy != mon_e.cy)
                        flag_mismatch("carry", got_e.cy, mon_e.cy);
                    if (got_e.idx != mon_e.idx)
                        flag_mismatch("entry_index", got_e.idx, mon_e.idx);
                    if (got_e.last != mon_e.last)
                        flag_mismatch("table_last", got_e.last, mon_e.last);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == rptg_pkg::REG_WIDTH)
                    cfg_width = cfg_data;
                else if (cfg_index == rptg_pkg::REG_KEEP)
                    cfg_keep = cfg_data[0];
            end
            if (req_valid && req_ready)
            begin
                accepted++;
                mon_has = next_entry(restart, mon_e);
                if (row_typed)
                begin
                    mon_has = 1'b1;
                    mon_e   = row_typed_e;
                end
                if (mon_has)
                    entry_q.insert(entry_q.size(), mon_e);
                else
                    silent++;
            end
        end
    end

    // Result side: random stalls, plus a long hold-off when asked for.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            res_ready <= 1'b0;
            hold_left--;
        end
        else if (hold_seen != hold_reqs)
        begin
            hold_seen = hold_reqs;
            hold_left = LONG_HOLD;
            res_ready <= 1'b0;
        end
        else
            res_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic push_request(input bit rs, input bit typed, input entry_t te);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid   <= 1'b1;
        restart     <= rs;
        row_typed   <= typed;
        row_typed_e <= te;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Drain every pending entry, then give a silent request time to finish.
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (entry_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rptg_pkg::CFG_IDX_W-1:0] sel,
                             input logic [rptg_pkg::ACC_W-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_items(input int n, input int unsigned rs_pct, input bit lead_rs);
        entry_t none;
        bit     rs;
        none = '0;
        for (int i = 0; i < n; i++)
        begin
            if (rnd_items < 200)
            begin
                tx_idle_pct = 37;
                rx_idle_pct = 61;
            end
            else if (rnd_items < 400)
            begin
                tx_idle_pct = 61;
                rx_idle_pct = 37;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            rs = (i == 0 && lead_rs) || ($urandom_range(99) < rs_pct);
            push_request(rs, 1'b0, none);
            rnd_items++;
        end
    endtask

    initial
    begin
        // start after reset, width 1 with fillers, forced weights, zero width
        plan_typed(1'b0, 8'hFF, 7'd64, rptg_pkg::CARRY_MAIN, 13'd0, 1'b0);
        plan_typed(1'b0, 8'hFF, 7'd64, rptg_pkg::CARRY_MAIN, 13'd1, 1'b0);
        plan_cfg(rptg_pkg::REG_WIDTH, 12'd1);
        plan_typed(1'b0, 8'hFF, 7'd64, rptg_pkg::CARRY_MAIN, 13'd2, 1'b0);
        plan_typed(1'b0, 8'h00, 7'd0, rptg_pkg::CARRY_NONE, 13'd3, 1'b0);
        plan_typed(1'b1, 8'hFF, 7'd64, rptg_pkg::CARRY_MAIN, 13'd0, 1'b0);
        plan_cfg(rptg_pkg::REG_KEEP, 12'd0);
        plan_typed(1'b0, 8'h3F, 7'd0, rptg_pkg::CARRY_NONE, 13'd1, 1'b0);
        plan_cfg(rptg_pkg::REG_WIDTH, 12'd0);
        plan_typed(1'b1, 8'hFF, 7'd64, rptg_pkg::CARRY_MAIN, 13'd0, 1'b0);
        plan_typed(1'b0, 8'h3F, 7'd0, rptg_pkg::CARRY_NONE, 13'd1, 1'b0);
        // widest setting, then the wide/narrow boundary with mid-table changes
        plan_cfg(rptg_pkg::REG_WIDTH, 12'd4095);
        plan_cfg(rptg_pkg::REG_KEEP, 12'd1);
        plan_typed(1'b1, 8'h7F, 7'd64, rptg_pkg::CARRY_NOWRAP, 13'd0, 1'b0);
        plan_req(1'b0);
        plan_cfg(rptg_pkg::REG_WIDTH, 12'd257);
        plan_req(1'b0);
        plan_typed(1'b1, 8'h7F, 7'd64, rptg_pkg::CARRY_NOWRAP, 13'd0, 1'b0);
        plan_req(1'b0);
        plan_cfg(rptg_pkg::REG_WIDTH, 12'd256);
        plan_req(1'b0);
        plan_cfg(rptg_pkg::REG_WIDTH, 12'd2);
        plan_typed(1'b1, 8'hFF, 7'd64, rptg_pkg::CARRY_MAIN, 13'd0, 1'b0);
        plan_typed(1'b0, 8'h00, 7'd0, rptg_pkg::CARRY_NONE, 13'd1, 1'b0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 37;
        rx_idle_pct = 61;
        foreach (plan_q[i])
        begin
            if (plan_q[i].kind == ROW_CFG)
                write_reg(plan_q[i].sel, plan_q[i].val);
            else
                push_request(plan_q[i].rs, plan_q[i].typed, plan_q[i].e);
        end

        // long wide table, past the narrow limit; the receiver holds off at first
        write_reg(rptg_pkg::REG_WIDTH, 12'($urandom_range(257, 4095)));
        write_reg(rptg_pkg::REG_KEEP, 12'd1);
        hold_reqs = hold_reqs + 1;
        run_items(258, 0, 1'b1);

        // switch to narrow with no restart: table is already over
        write_reg(rptg_pkg::REG_WIDTH, 12'($urandom_range(32, 256)));
        write_reg(rptg_pkg::REG_KEEP, 12'd0);
        run_items(3, 0, 1'b0);
        run_items(265, 0, 1'b1);

        for (int k = 0; k < 3; k++)
        begin
            if (k == 1)
                write_reg(rptg_pkg::REG_WIDTH, 12'($urandom_range(0, 4095)));
            else
                write_reg(rptg_pkg::REG_WIDTH, 12'($urandom_range(1, 256)));
            write_reg(rptg_pkg::REG_KEEP, 12'($urandom_range(1)));
            if (k == 1)
                hold_reqs = hold_reqs + 1;
            run_items(20, 10, 1'($urandom_range(1)));
        end

        settle();
        if (entry_q.size() != 0)
            flag_mismatch("entries never returned", 0, entry_q.size());
        $display("requests accepted: %0d, entries checked: %0d, silent requests: %0d",
                 accepted, checked, silent);
        $display("tables closed: %0d, mismatches: %0d", tables_done, errors);
        if (errors == 0)
            $display("** resample_phase_table_generator: PASSED **");
        else
            $display("** resample_phase_table_generator: FAILED **");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("timeout with %0d entries pending", entry_q.size());
        $display("** resample_phase_table_generator: FAILED **");
        $finish;
    end

endmodule
